### sv/actr_pkg.sv
//------------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and AES helper functions for the CTR byte cipher.
//------------------------------------------------------------------------------
package actr_pkg;

	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0   = 3'd0,
		REG_KEY1   = 3'd1,
		REG_KEY2   = 3'd2,
		REG_KEY3   = 3'd3,
		REG_KSIZE  = 3'd4,
		REG_IV_HI  = 3'd5,
		REG_IV_LO  = 3'd6,
		REG_UNUSED = 3'd7
	} cfg_reg_t;

	localparam logic [1:0] KSIZE_128 = 2'd0;
	localparam logic [1:0] KSIZE_192 = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYX,
		ST_ROUND,
		ST_OUT
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;      // load state from counter, seed key schedule
		logic key_step;   // expand one key word
		logic round_step; // advance a cipher round by one round-key column
		logic finish;     // latch keystream, bump counter, rewind position
		logic consume;    // deliver one byte
	} actr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_block; // keystream used up
		logic keys_done;  // last round-key word being expanded
		logic last_round; // final column of the final round
	} actr_sts_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

### sv/actr_ram.sv
//------------------------------------------------------------------------------
// actr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
module actr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/actr_ctrl.sv
//------------------------------------------------------------------------------
// actr_ctrl
// Sequencer: key expansion and round iteration when keystream is used up, then byte delivery.
//------------------------------------------------------------------------------
module actr_ctrl
	import actr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  actr_sts_t sts,
	output actr_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.need_block) begin
						cmd.start = 1'b1;
						state_d   = ST_KEYX;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_KEYX: begin
				cmd.key_step = 1'b1;
				if (sts.keys_done) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (sts.last_round) begin
					cmd.finish = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					in_stall    = 1'b0;
					cmd.consume = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### sv/actr_dp.sv
//------------------------------------------------------------------------------
// actr_dp
// Datapath: config registers, counter, key schedule RAM, round unit, keystream.
//------------------------------------------------------------------------------
module actr_dp
	import actr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]            data_in,
	output logic [7:0]            data_out,
	input  actr_cmd_t             cmd,
	output actr_sts_t             sts
);

	localparam int unsigned RK_WORDS = 60;
	localparam int unsigned RK_AW    = $clog2(RK_WORDS);

	logic [63:0]  key_q [4];
	logic [1:0]   ksize_q;
	logic [63:0]  iv_hi_q, iv_lo_q;
	logic [127:0] ctr_q, ks_q, st_q;
	logic [4:0]   pos_q;
	logic [RK_AW-1:0] kw_q;      // next key word index being written
	logic [31:0]  w_q [8];       // sliding window of the last nk words
	logic [2:0]   kmod_q;        // kw mod nk
	logic [7:0]   rcon_q;
	logic [3:0]   rnd_q;         // round being run (0 = initial whitening)
	logic [1:0]   col_q;         // round key column fetched
	logic [127:0] rk_acc_q;

	logic [3:0]  nk, nr;
	logic [RK_AW-1:0] total_words;
	logic [31:0] prev_w, tw, new_w;
	logic        rk_we;
	logic [RK_AW-1:0] rk_ra;
	logic [31:0] rk_rd;

	always_comb begin
		unique case (ksize_q)
			KSIZE_128: nk = 4'd4;
			KSIZE_192: nk = 4'd6;
			default:   nk = 4'd8;
		endcase
		nr          = nk + 4'd6;
		total_words = RK_AW'({nr, 2'b00} + 6'd4);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '{default: '0};
			ksize_q <= '0;
			iv_hi_q <= '0;
			iv_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_KEY0:  key_q[0] <= cfg_data;
				REG_KEY1:  key_q[1] <= cfg_data;
				REG_KEY2:  key_q[2] <= cfg_data;
				REG_KEY3:  key_q[3] <= cfg_data;
				REG_KSIZE: ksize_q  <= cfg_data[1:0];
				REG_IV_HI: iv_hi_q  <= cfg_data;
				REG_IV_LO: iv_lo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// key word generation: one word per cycle
	always_comb begin
		prev_w = w_q[nk[2:0] - 3'd1];
		if (kmod_q == 3'd0) begin
			tw = {sbox(prev_w[23:16]) ^ rcon_q, sbox(prev_w[15:8]),
				sbox(prev_w[7:0]), sbox(prev_w[31:24])};
		end else if (nk == 4'd8 && kmod_q == 3'd4) begin
			tw = {sbox(prev_w[31:24]), sbox(prev_w[23:16]),
				sbox(prev_w[15:8]), sbox(prev_w[7:0])};
		end else begin
			tw = prev_w;
		end
		new_w = (kw_q < RK_AW'(nk)) ? key_q[kw_q[2:1]][(kw_q[0] ? 31 : 63) -: 32]
			: w_q[0] ^ tw;
	end

	assign rk_we = cmd.key_step;
	assign sts.keys_done = (kw_q == total_words - RK_AW'(1));

	// round key read: column col of round rnd, its address issued in the cycle before
	logic [RK_AW-1:0] rd_ptr_q;
	assign rk_ra = rd_ptr_q;

	actr_ram #(.WIDTH(32), .DEPTH(RK_WORDS)) u_rk (
		.clk  (clk),
		.we   (rk_we),
		.waddr(kw_q),
		.wdata(new_w),
		.raddr(rk_ra),
		.rdata(rk_rd)
	);

	// round function
	logic [127:0] sub_sh, mixed, round_in;
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				sub_sh[127 - 8*(i+4*c) -: 8] = sbox(st_q[127 - 8*(i + 4*((c+i)&3)) -: 8]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sub_sh[127 - 32*c -: 8];
			a1 = sub_sh[119 - 32*c -: 8];
			a2 = sub_sh[111 - 32*c -: 8];
			a3 = sub_sh[103 - 32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mixed[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			mixed[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			mixed[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mixed[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		if (rnd_q == 4'd0) begin
			round_in = st_q;
		end else if (rnd_q == nr) begin
			round_in = sub_sh;
		end else begin
			round_in = mixed;
		end
	end

	// Each round takes four round steps: the first three gather round-key
	// columns, the fourth applies the round with the last column from the RAM.
	logic [127:0] rk_full;
	assign rk_full = {rk_acc_q[95:0], rk_rd};
	assign sts.last_round = (rnd_q == nr) && (col_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			ks_q   <= '0;
			pos_q  <= 5'(BLOCK_BYTES);
			kw_q   <= '0;
			kmod_q <= '0;
			rcon_q <= 8'h01;
			rnd_q  <= '0;
			col_q  <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cfg_we && (cfg_reg_t'(cfg_idx) == REG_IV_HI
				|| cfg_reg_t'(cfg_idx) == REG_IV_LO)) begin
				ctr_q <= (cfg_reg_t'(cfg_idx) == REG_IV_HI) ? {cfg_data, iv_lo_q}
					: {iv_hi_q, cfg_data};
				pos_q <= 5'(BLOCK_BYTES);
			end
			if (cmd.start) begin
				kw_q     <= '0;
				kmod_q   <= '0;
				rcon_q   <= 8'h01;
				rnd_q    <= '0;
				col_q    <= '0;
				rd_ptr_q <= '0;
			end
			if (cmd.key_step) begin
				kw_q <= kw_q + RK_AW'(1);
				if (kw_q >= RK_AW'(nk)) begin
					if (kmod_q == 3'd0) begin
						rcon_q <= xtime(rcon_q);
					end
					kmod_q <= (kmod_q == nk[2:0] - 3'd1) ? 3'd0 : kmod_q + 3'd1;
				end
				if (sts.keys_done) begin
					rd_ptr_q <= RK_AW'(1);
				end
			end
			if (cmd.round_step) begin
				col_q    <= col_q + 2'd1;
				rd_ptr_q <= rd_ptr_q + RK_AW'(1);
				if (col_q == 2'd3) begin
					rnd_q <= rnd_q + 4'd1;
				end
			end
			if (cmd.finish) begin
				ks_q  <= round_in ^ rk_full;
				ctr_q <= ctr_q + 128'd1;
				pos_q <= '0;
			end
			if (cmd.consume) begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	// Key window and state registers: payload, no reset.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			st_q <= ctr_q;
		end
		if (cmd.key_step) begin
			// Shift the window down; the newest word lands at slot nk-1.
			for (int i = 0; i < 8; i++) begin
				if (i == 7 || 3'(i) == nk[2:0] - 3'd1) begin
					w_q[i] <= new_w;
				end else begin
					w_q[i] <= w_q[3'(i + 1)];
				end
			end
		end
		if (cmd.round_step) begin
			rk_acc_q <= rk_full;
			if (col_q == 2'd3) begin
				st_q <= round_in ^ rk_full;
			end
		end
	end

	assign sts.need_block = pos_q[4];
	assign data_out = data_in ^ ks_q[127 - 8*pos_q[3:0] -: 8];

endmodule

### sv/aes_ctr_stream_cipher_unit.sv
//------------------------------------------------------------------------------
// aes_ctr_stream_cipher_unit
// AES counter-mode byte cipher: data_out = data_in XOR next keystream byte.
//------------------------------------------------------------------------------
// While keystream remains, a byte's input is seen in IDLE, then its input and
// output transactions complete together in OUT, which holds while out_stall
// is high. A new keystream block first re-expands the whole key schedule,
// then runs the rounds (one round-key column a cycle). One byte in flight at
// a time. Reset: counter and keys zero, keystream empty so the first byte
// triggers block generation; no RAM clearing.
//------------------------------------------------------------------------------
module aes_ctr_stream_cipher_unit
	import actr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_in,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            data_out
);

	actr_cmd_t cmd;
	actr_sts_t sts;

	// Sequence one transaction: generate keystream if used up, then deliver.
	actr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold config, counter, key schedule and keystream; XOR the input byte.
	actr_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.data_in (data_in),
		.data_out(data_out),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule
